/* rtl/core/isl_pkg.sv */
package isl_pkg;

  // Default sizing of the list.
  localparam int unsigned CAPACITY   = 16;
  localparam int unsigned DATA_WIDTH = 32;

  // Fixed widths of the transaction fields.
  localparam int unsigned PosW   = 5;
  localparam int unsigned ValueW = 32;
  localparam int unsigned CountW = 5;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_DELETE  = 2'd1,
    OP_READ    = 2'd2,
    OP_REVERSE = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  // Request transaction.
  typedef struct packed {
    opcode_e            opcode;
    logic [PosW-1:0]    position;
    logic [ValueW-1:0]  value;
  } req_t;

  // Response transaction.
  typedef struct packed {
    logic [ValueW-1:0]  read_value;
    logic [CountW-1:0]  count;
    status_e            status;
  } rsp_t;

  // Action broadcast to every cell of the chain.
  typedef struct packed {
    logic ins;  // insert accepted
    logic del;  // delete accepted
  } cell_cmd_t;

endpackage

/* rtl/core/isl_cell.sv */
module isl_cell #(
  parameter int unsigned DATA_WIDTH = isl_pkg::DATA_WIDTH,
  parameter int unsigned IDX_W      = 4,
  parameter int unsigned INDEX      = 0
) (
  input  logic                  clk_i,
  input  isl_pkg::cell_cmd_t    cmd_i,
  input  logic [IDX_W-1:0]      q_i,
  input  logic [DATA_WIDTH-1:0] value_i,
  input  logic [DATA_WIDTH-1:0] left_i,
  input  logic [DATA_WIDTH-1:0] right_i,
  output logic [DATA_WIDTH-1:0] data_o
);

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(INDEX);

  logic [DATA_WIDTH-1:0] data_q, data_d;
  logic                  take_left, take_right, take_value;

  // Decide which neighbor this cell copies. The list always fills the row
  // from cell zero upward, so an insert opens a gap by shifting the cells
  // above the target up, and a delete closes it by shifting them down.
  always_comb begin
    take_value = cmd_i.ins && (MyIdx == q_i);
    take_left  = cmd_i.ins && (MyIdx > q_i);
    take_right = cmd_i.del && (MyIdx >= q_i);
  end

  always_comb begin
    priority if (take_value) begin
      data_d = value_i;
    end else if (take_left) begin
      data_d = left_i;
    end else if (take_right) begin
      data_d = right_i;
    end else begin
      data_d = data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

/* rtl/core/indexed_sequence_list.sv */
// A response is registered and presented in the cycle after its request is accepted.
// Throughput: one request per cycle while responses are taken at once; a new
// request enters in the cycle the waiting response leaves, and a stalled
// response blocks the input. Reverse only flips the orientation flag, so it
// moves no data. Reset clears the count, orientation and output valid; cell
// contents stay undefined until written.
module indexed_sequence_list #(
  parameter int unsigned CAPACITY   = isl_pkg::CAPACITY,
  parameter int unsigned DATA_WIDTH = isl_pkg::DATA_WIDTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  isl_pkg::req_t in_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output isl_pkg::rsp_t out_o
);

  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned CmpW = (CntW > isl_pkg::PosW) ? CntW : isl_pkg::PosW;
  localparam logic [CmpW-1:0] CapX    = CmpW'(CAPACITY);

  logic                  fire;
  logic                  rev;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  dir_q, dir_d;
  logic                  out_valid_q;
  isl_pkg::rsp_t         out_q, rsp_d;
  isl_pkg::status_e      st;
  isl_pkg::cell_cmd_t    cmd;
  logic [CmpW-1:0]       pos_x, cnt_x, q_x;
  logic [IdxW-1:0]       q;
  logic [63:0]           val_wide, rd_wide;
  logic [DATA_WIDTH-1:0] val_w;
  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];

  // Handshake: the output register frees up when its response is taken.
  assign fire       = in_valid_i && in_ready_o;
  assign in_ready_o = !out_valid_q || out_ready_i;

  assign pos_x   = CmpW'(in_i.position);
  assign cnt_x   = CmpW'(cnt_q);

  // Logical position to physical cell. The list always occupies cells zero
  // to count-1; in normal orientation position p is cell p, once reversed it
  // is cell count-1-p, and an insert then lands at cell count-p.
  always_comb begin
    if (!dir_q) begin
      q_x = pos_x;
    end else if (in_i.opcode == isl_pkg::OP_INSERT) begin
      q_x = cnt_x - pos_x;
    end else begin
      q_x = cnt_x - pos_x - CmpW'(1);
    end
  end

  assign q = q_x[IdxW-1:0];

  assign val_wide = 64'(in_i.value);
  assign val_w    = val_wide[DATA_WIDTH-1:0];

  // Request checks; full and empty take precedence over range.
  always_comb begin
    st = isl_pkg::ST_OK;
    unique case (in_i.opcode)
      isl_pkg::OP_INSERT: begin
        if (cnt_x >= CapX) begin
          st = isl_pkg::ST_FULL;
        end else if (pos_x > cnt_x) begin
          st = isl_pkg::ST_RANGE;
        end
      end
      isl_pkg::OP_DELETE, isl_pkg::OP_READ: begin
        if (cnt_q == '0) begin
          st = isl_pkg::ST_EMPTY;
        end else if (pos_x >= cnt_x) begin
          st = isl_pkg::ST_RANGE;
        end
      end
      default: st = isl_pkg::ST_OK;
    endcase
  end

  // Command broadcast to the cell row.
  always_comb begin
    cmd.ins = fire && (in_i.opcode == isl_pkg::OP_INSERT) && (st == isl_pkg::ST_OK);
    cmd.del = fire && (in_i.opcode == isl_pkg::OP_DELETE) && (st == isl_pkg::ST_OK);
    rev     = fire && (in_i.opcode == isl_pkg::OP_REVERSE);
  end

  // Next count and orientation.
  always_comb begin
    cnt_d = cnt_q;
    dir_d = dir_q;
    if (cmd.ins) begin
      cnt_d = cnt_q + CntW'(1);
    end
    if (cmd.del) begin
      cnt_d = cnt_q - CntW'(1);
    end
    if (rev) begin
      dir_d = !dir_q;
    end
  end

  // Row of cells, each wired to its neighbors.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] left, right;
    if (g == 0) begin : g_lo
      assign left = '0;
    end else begin : g_lo_n
      assign left = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_hi
      assign right = '0;
    end else begin : g_hi_n
      assign right = cell_data[g+1];
    end
    isl_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .IDX_W      (IdxW),
      .INDEX      (g)
    ) u_cell (
      .clk_i    (clk_i),
      .cmd_i    (cmd),
      .q_i      (q),
      .value_i  (val_w),
      .left_i   (left),
      .right_i  (right),
      .data_o   (cell_data[g])
    );
  end

  // Response; the read word is zero unless the read succeeds.
  always_comb begin
    rd_wide = '0;
    if ((in_i.opcode == isl_pkg::OP_READ) && (st == isl_pkg::ST_OK)) begin
      rd_wide = 64'(cell_data[q]);
    end
    rsp_d.read_value = rd_wide[isl_pkg::ValueW-1:0];
    rsp_d.count      = isl_pkg::CountW'(cnt_d);
    rsp_d.status     = st;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      dir_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      dir_q <= dir_d;
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // The count never goes past the capacity.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CmpW'(cnt_q) <= CapX)
    else $error("element count above capacity");

  // A rejected request changes nothing.
  a_reject_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (st != isl_pkg::ST_OK)) |=> ($stable(cnt_q) && $stable(dir_q)))
    else $error("rejected request changed the list");

  // Every accepted request leaves a response behind.
  a_rsp_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("accepted request produced no response");

  // Reverse flips the orientation and keeps the count.
  a_rev_flip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rev |=> ((dir_q != $past(dir_q)) && $stable(cnt_q)))
    else $error("reverse did not flip orientation");

endmodule
